### rtl/core/assert_macros.svh
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define U8D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define U8D_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset-time check failed");

`endif

### rtl/core/u8d_pkg.sv
package u8d_pkg;

  // Result kinds on out_tuser.
  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_TERM = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEQ  = 3'b010,
    PH_DROP = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    JOB_TEXT,
    JOB_TERM,
    JOB_ERR,
    JOB_ESC
  } job_op_t;

  // One unit of work for the back end.
  typedef struct packed {
    job_op_t     op;
    logic [7:0]  ch;        // passthrough character
    logic [20:0] cp;        // finished code point
    logic [2:0]  ndig;      // hex digits, 4..6
    logic        add_term;  // terminator follows
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = 8'h37 + {4'h0, d};
    end
    return c;
  endfunction

endpackage

### rtl/core/u8d_front.sv
module u8d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              push,
  output u8d_pkg::job_t     push_job
);

  u8d_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      left_r, left_nxt;
  logic [20:0]     acc_r, acc_nxt;
  logic            job_vld;
  logic            ends;
  logic            is_cont;
  logic [20:0]     acc_shift;
  logic            accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign ends      = in_tlast || (in_tdata == 8'h00);
  assign is_cont   = (in_tdata[7:6] == 2'b10);
  assign acc_shift = {acc_r[14:0], in_tdata[5:0]};
  assign push      = accept && job_vld;

  always_comb begin
    phase_nxt         = phase_r;
    left_nxt          = left_r;
    acc_nxt           = acc_r;
    job_vld           = 1'b0;
    push_job.op       = u8d_pkg::JOB_ERR;
    push_job.ch       = in_tdata;
    push_job.cp       = acc_shift;
    push_job.add_term = 1'b0;
    push_job.ndig     = acc_shift[20] ? 3'd6 : ((acc_shift[19:16] != 4'h0) ? 3'd5 : 3'd4);
    unique case (phase_r)
      u8d_pkg::PH_DROP: begin
        if (ends) begin
          phase_nxt = u8d_pkg::PH_IDLE;
        end
      end
      u8d_pkg::PH_SEQ: begin
        job_vld = 1'b0;
        if (is_cont) begin
          acc_nxt = acc_shift;
          if (left_r <= 2'd1) begin
            left_nxt          = 2'd0;
            phase_nxt         = u8d_pkg::PH_IDLE;
            job_vld           = 1'b1;
            push_job.op       = u8d_pkg::JOB_ESC;
            push_job.add_term = ends;
          end else begin
            left_nxt = left_r - 2'd1;
            if (ends) begin
              job_vld   = 1'b1;
              phase_nxt = u8d_pkg::PH_IDLE;
              left_nxt  = 2'd0;
            end
          end
        end else begin
          job_vld   = 1'b1;
          left_nxt  = 2'd0;
          phase_nxt = ends ? u8d_pkg::PH_IDLE : u8d_pkg::PH_DROP;
        end
      end
      default: begin
        // idle, and any stray code
        phase_nxt = u8d_pkg::PH_IDLE;
        job_vld   = 1'b1;
        if (in_tdata == 8'h00) begin
          push_job.op = u8d_pkg::JOB_TERM;
        end else if (!in_tdata[7]) begin
          push_job.op       = u8d_pkg::JOB_TEXT;
          push_job.add_term = ends;
        end else if (in_tdata[7:5] == 3'b110 || in_tdata[7:4] == 4'b1110 ||
                     in_tdata[7:3] == 5'b11110) begin
          if (in_tdata[7:5] == 3'b110) begin
            acc_nxt  = {16'h0, in_tdata[4:0]};
            left_nxt = 2'd1;
          end else if (in_tdata[7:4] == 4'b1110) begin
            acc_nxt  = {17'h0, in_tdata[3:0]};
            left_nxt = 2'd2;
          end else begin
            acc_nxt  = {18'h0, in_tdata[2:0]};
            left_nxt = 2'd3;
          end
          if (ends) begin
            left_nxt = left_r;  // truncated lead: error, count untouched
          end else begin
            job_vld   = 1'b0;
            phase_nxt = u8d_pkg::PH_SEQ;
          end
        end else begin
          phase_nxt = ends ? u8d_pkg::PH_IDLE : u8d_pkg::PH_DROP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= u8d_pkg::PH_IDLE;
      left_r  <= 2'd0;
      acc_r   <= 21'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

### rtl/core/u8d_queue.sv
module u8d_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u8d_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_vld,
  output u8d_pkg::job_t head_job
);

  u8d_pkg::job_t                mem [u8d_pkg::Q_DEPTH];
  logic [u8d_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [u8d_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [u8d_pkg::Q_AW:0]       cnt_r, cnt_nxt;

  assign full     = (cnt_r == (u8d_pkg::Q_AW+1)'(u8d_pkg::Q_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_job = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{u8d_pkg::Q_AW{1'b0}}, push} - {{u8d_pkg::Q_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/core/u8d_back.sv
module u8d_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_vld,
  input  u8d_pkg::job_t head_job,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);

  u8d_pkg::job_t job_r, job_nxt;
  logic          busy_r, busy_nxt;
  logic [3:0]    step_r, step_nxt;
  logic          ovld_r, ovld_nxt;
  logic [7:0]    ochar_r, ochar_nxt;
  logic [1:0]    okind_r, okind_nxt;
  logic          olast_r, olast_nxt;

  logic          adv;
  logic [3:0]    base;
  logic [3:0]    total;
  logic          is_last;
  logic [2:0]    dig_idx;
  logic [3:0]    nib;
  logic [7:0]    r_char;
  logic [1:0]    r_kind;

  assign adv     = !ovld_r || out_tready;
  assign base    = (job_r.op == u8d_pkg::JOB_ESC) ? 4'd2 + {1'b0, job_r.ndig} : 4'd1;
  assign total   = base + {3'b000, job_r.add_term};
  assign is_last = (step_r == total - 4'd1);
  assign dig_idx = job_r.ndig + 3'd1 - step_r[2:0];
  assign pop     = head_vld && (!busy_r || (adv && is_last));

  always_comb begin
    unique case (dig_idx)
      3'd0:    nib = job_r.cp[3:0];
      3'd1:    nib = job_r.cp[7:4];
      3'd2:    nib = job_r.cp[11:8];
      3'd3:    nib = job_r.cp[15:12];
      3'd4:    nib = job_r.cp[19:16];
      3'd5:    nib = {3'b000, job_r.cp[20]};
      default: nib = 4'h0;
    endcase
  end

  always_comb begin
    r_char = 8'h00;
    r_kind = u8d_pkg::KIND_TEXT;
    if (step_r == base) begin
      r_kind = u8d_pkg::KIND_TERM;
    end else begin
      unique case (job_r.op)
        u8d_pkg::JOB_TEXT: r_char = job_r.ch;
        u8d_pkg::JOB_TERM: r_kind = u8d_pkg::KIND_TERM;
        u8d_pkg::JOB_ERR:  r_kind = u8d_pkg::KIND_ERR;
        u8d_pkg::JOB_ESC: begin
          if (step_r == 4'd0) begin
            r_char = u8d_pkg::CHAR_BSLASH;
          end else if (step_r == 4'd1) begin
            r_char = u8d_pkg::CHAR_U;
          end else begin
            r_char = u8d_pkg::hex_char(nib);
          end
        end
        default: r_kind = u8d_pkg::KIND_ERR;
      endcase
    end
  end

  always_comb begin
    job_nxt   = job_r;
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    ovld_nxt  = ovld_r;
    ochar_nxt = ochar_r;
    okind_nxt = okind_r;
    olast_nxt = olast_r;
    if (adv) begin
      ovld_nxt = busy_r;
      if (busy_r) begin
        ochar_nxt = r_char;
        okind_nxt = r_kind;
        olast_nxt = is_last;
        step_nxt  = step_r + 4'd1;
        if (is_last) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (pop) begin
      job_nxt  = head_job;
      busy_nxt = 1'b1;
      step_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
      step_r <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    ochar_r <= ochar_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = ochar_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

endmodule

### rtl/core/utf8_to_unicode_escape_decoder_unit.sv
// UTF-8 to "\u" escape decoder. Bytes of UTF-8 text enter one per item on the
// in_ stream (in_tlast marks a string's final byte; a zero byte ends a string
// too). ASCII passes through as one text result; a 2, 3 or 4 byte sequence
// becomes '\', 'u' and 4 to 6 uppercase hex digits; each good string closes
// with one terminator result (kind 1, data 0). A bad lead byte, a missing
// continuation byte or a string that ends mid-sequence gives one error result
// (kind 2) and the rest of the string is dropped with no terminator. Overlong
// forms and surrogates are not rejected. out_tlast flags the final result
// caused by each input byte. Rate: the front end takes at most one byte a
// cycle and hands work to a 4-entry queue; the back end emits one result a
// cycle while the receiver is ready, with no gap between jobs; a byte gives 0
// to 9 results, about 3 a byte on two-byte text and 1 on plain ASCII. The
// input stalls only when the queue fills. The first result of a byte passes
// through the queue, the back end's job register and its output register.
// Both stream sides may stall independently; no clearing pass after reset.
module utf8_to_unicode_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // string_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast   // run_last
);

  // front end to queue
  logic          q_full;
  logic          push;
  u8d_pkg::job_t push_job;

  // queue to back end
  logic          head_vld;
  u8d_pkg::job_t head_job;
  logic          pop;

  // Byte classifier and sequence tracker: one job per byte that yields output.
  u8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // Decouples byte intake from result expansion.
  u8d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .head_vld (head_vld),
    .head_job (head_job)
  );

  // Expands each job into its results, one per cycle unless the receiver stalls, through an output reg.
  u8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (head_vld),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/core/u8d_checker.sv
`include "assert_macros.svh"

module u8d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  logic in_seen;
  assign in_seen = in_tvalid && in_tready && (in_tdata != 8'h00 || in_tlast || !in_tlast);

  `U8D_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `U8D_ASSERT_NOW(a_ctrl_shape, clk, rst_n, out_tvalid && out_tuser != u8d_pkg::KIND_TEXT, out_tdata == 8'h00 && out_tlast)
  `U8D_ASSERT_NOW(a_text_nonzero, clk, rst_n, out_tvalid && out_tuser == u8d_pkg::KIND_TEXT, out_tdata != 8'h00)
  `U8D_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid && !in_seen)

endmodule

bind utf8_to_unicode_escape_decoder_unit u8d_checker u_chk (.*);

### dv/utf8_to_unicode_escape_decoder_unit_tb.sv
`timescale 1ns / 100ps

module utf8_to_unicode_escape_decoder_unit_tb;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int RANDOM_ITEMS   = 110;
  localparam int DRAIN_CYCLES   = 16;

  // Character n of the hex digit set sits in byte n.
  localparam logic [127:0] HEX_ASCII = "FEDCBA9876543210";

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] kind;
    logic       last;
  } esc_char_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  // Results still owed by the block, oldest first.
  esc_char_t pending_chars[$];

  // Predictor state: mirrors the decoder front end.
  u8d_pkg::phase_t dec_phase = u8d_pkg::PH_IDLE;
  logic [1:0]      dec_left  = 2'd0;
  logic [20:0]     dec_acc   = 21'd0;
  esc_char_t       held_char;
  bit              have_held = 1'b0;

  int mismatch_count = 0;
  int live_items     = 0;   // accepted items that were not just dropped
  int cycle_count    = 0;

  // Stimulus knobs. tx_steady / rx_steady switch off random idling on a side;
  // hold_req asks the receiver for one long hold-off.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  utf8_to_unicode_escape_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .in_tlast   (in_tlast),    // string_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_char
    .out_tuser  (out_tuser),   // [1:0] kind
    .out_tlast  (out_tlast)    // run_last
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Results of one byte are held back by one so the final one can carry last.
  function automatic void owe_char(input logic [7:0] ch, input logic [1:0] kind);
    if (have_held) begin
      pending_chars.push_back(held_char);
    end
    held_char = '{ch: ch, kind: kind, last: 1'b0};
    have_held = 1'b1;
  endfunction

  // '\', 'u', then 4..6 uppercase hex digits, as many as the value needs.
  function automatic void owe_escape(input logic [20:0] cp);
    int          ndig;
    int          i;
    logic [20:0] rest;
    logic [3:0]  nib;
    ndig = 1;
    rest = cp >> 4;
    while (rest != 21'd0 && ndig < 6) begin
      ndig++;
      rest = rest >> 4;
    end
    if (ndig < 4) begin
      ndig = 4;
    end
    owe_char(u8d_pkg::CHAR_BSLASH, u8d_pkg::KIND_TEXT);
    owe_char(u8d_pkg::CHAR_U, u8d_pkg::KIND_TEXT);
    for (i = ndig - 1; i >= 0; i--) begin
      nib = 4'((cp >> (4 * i)) & 21'hF);
      owe_char(HEX_ASCII[8 * nib +: 8], u8d_pkg::KIND_TEXT);
    end
  endfunction

  function automatic void decode_utf8_byte(input logic [7:0] b, input logic tl);
    logic       ends;
    logic [1:0] need;
    ends = tl || (b == 8'h00);
    if (dec_phase != u8d_pkg::PH_DROP) begin
      live_items++;
    end
    case (dec_phase)
      u8d_pkg::PH_DROP: begin
        // silent until the string ends
        if (ends) begin
          dec_phase = u8d_pkg::PH_IDLE;
        end
      end
      u8d_pkg::PH_SEQ: begin
        if (b[7:6] == 2'b10) begin
          dec_acc = {dec_acc[14:0], b[5:0]};
          if (dec_left <= 2'd1) begin
            dec_left  = 2'd0;
            dec_phase = u8d_pkg::PH_IDLE;
            owe_escape(dec_acc);
            if (ends) begin
              owe_char(8'h00, u8d_pkg::KIND_TERM);
            end
          end else begin
            dec_left--;
            // string closed mid-sequence
            if (ends) begin
              owe_char(8'h00, u8d_pkg::KIND_ERR);
              dec_phase = u8d_pkg::PH_IDLE;
              dec_left  = 2'd0;
            end
          end
        end else begin
          // missing continuation byte
          owe_char(8'h00, u8d_pkg::KIND_ERR);
          dec_left  = 2'd0;
          dec_phase = ends ? u8d_pkg::PH_IDLE : u8d_pkg::PH_DROP;
        end
      end
      default: begin
        dec_phase = u8d_pkg::PH_IDLE;
        if (b == 8'h00) begin
          owe_char(8'h00, u8d_pkg::KIND_TERM);
        end else if (b[7] == 1'b0) begin
          owe_char(b, u8d_pkg::KIND_TEXT);
          if (ends) begin
            owe_char(8'h00, u8d_pkg::KIND_TERM);
          end
        end else begin
          need = 2'd0;
          if (b[7:5] == 3'b110) begin
            dec_acc = {16'd0, b[4:0]};
            need    = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            dec_acc = {17'd0, b[3:0]};
            need    = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            dec_acc = {18'd0, b[2:0]};
            need    = 2'd3;
          end
          if (need == 2'd0) begin
            // invalid lead byte
            owe_char(8'h00, u8d_pkg::KIND_ERR);
            dec_phase = ends ? u8d_pkg::PH_IDLE : u8d_pkg::PH_DROP;
          end else if (ends) begin
            owe_char(8'h00, u8d_pkg::KIND_ERR);
          end else begin
            dec_left  = need;
            dec_phase = u8d_pkg::PH_SEQ;
          end
        end
      end
    endcase
    if (have_held) begin
      held_char.last = 1'b1;
      pending_chars.push_back(held_char);
      have_held = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted item, then check each accepted result.
  // Predicting first keeps a same-edge push and pop in a fixed order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    esc_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_utf8_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected result: out_char %h kind %0d run_last %0d",
                 out_tdata, out_tuser, out_tlast);
          mismatch_count++;
        end else begin
          want = pending_chars.pop_front();
          if (out_tdata !== want.ch) begin
            $error("out_char mismatch: expected %h, actual %h", want.ch, out_tdata);
            mismatch_count++;
          end
          if (out_tuser !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_tuser);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("run_last mismatch: expected %0d, actual %0d", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, a steady mode, and one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left  <= RX_HOLD_CYCLES;
      hold_req    = 1'b0;
    end else begin
      out_tready <= rx_steady || ($urandom_range(99) >= 34);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item and return at the edge it is accepted. Starts and ends at a
  // rising edge; valid only drops when an idle gap is inserted.
  task automatic send_byte(input logic [7:0] b, input logic tl);
    if (!tx_steady) begin
      while ($urandom_range(99) < 34) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= tl;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] utf8_lead(input int nbytes);
    case (nbytes)
      2:       return 8'($urandom_range(8'hC0, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  // A well-formed character; tl goes on its final byte.
  task automatic send_good_char(input logic tl);
    int pick;
    int nb;
    int j;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_byte(8'($urandom_range(1, 127)), tl);
    end else begin
      nb = (pick < 65) ? 2 : (pick < 85) ? 3 : 4;
      send_byte(utf8_lead(nb), 1'b0);
      for (j = 1; j < nb; j++) begin
        send_byte(8'($urandom_range(8'h80, 8'hBF)), tl && (j == nb - 1));
      end
    end
  endtask

  // Bad lead, missing continuation, truncated sequence or raw noise.
  task automatic send_broken_piece();
    int sel;
    int nb;
    int j;
    sel = $urandom_range(3);
    case (sel)
      0: begin
        if ($urandom_range(1) == 0) begin
          send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
        end else begin
          send_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
        end
      end
      1: begin
        nb = $urandom_range(2, 4);
        send_byte(utf8_lead(nb), 1'b0);
        for (j = 1; j < $urandom_range(1, nb - 1); j++) begin
          send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
        end
        if ($urandom_range(1) == 0) begin
          send_byte(8'($urandom_range(8'h00, 8'h7F)), 1'($urandom_range(1)));
        end else begin
          send_byte(8'($urandom_range(8'hC0, 8'hFF)), 1'($urandom_range(1)));
        end
      end
      2: begin
        // ends before the last continuation byte
        nb = $urandom_range(2, 4);
        if (nb == 2) begin
          send_byte(utf8_lead(nb), 1'b1);
        end else begin
          send_byte(utf8_lead(nb), 1'b0);
          for (j = 1; j < nb - 1; j++) begin
            send_byte(8'($urandom_range(8'h80, 8'hBF)), j == nb - 2);
          end
        end
      end
      default: begin
        for (j = 0; j < $urandom_range(1, 4); j++) begin
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // ASCII passthrough and zero-byte string ends.
  task automatic test_ascii_passthrough();
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);   // text then terminator
    send_byte(8'h00, 1'b0);   // zero byte alone ends the string
    send_byte(8'h00, 1'b1);
  endtask

  // Escapes of 4, 5 and 6 digits; overlong and surrogate forms pass.
  task automatic test_escape_lengths();
    send_byte(8'hC0, 1'b0);   // overlong zero -> \u0000
    send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0);   // surrogate D800
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b0);   // 10000 -> five digits
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF7, 1'b0);   // 1FFFFF -> six digits, then terminator
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_decode_errors();
    send_byte(8'h80, 1'b0);   // stray continuation as lead, then dropping
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);   // ends the dropped string silently
    send_byte(8'hFF, 1'b1);   // bad lead that also ends the string
    send_byte(8'hC3, 1'b0);   // missing continuation
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hE2, 1'b0);   // string ends mid-sequence
    send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b1);   // lead byte that ends the string
    send_byte(8'hC3, 1'b0);   // zero where a continuation is due
    send_byte(8'h00, 1'b0);
  endtask

  // Receiver holds off while three-byte text keeps coming, so the block's
  // queue fills and in_tready drops.
  task automatic test_back_pressure();
    int k;
    tx_steady = 1'b1;
    hold_req  = 1'b1;
    for (k = 0; k < 12; k++) begin
      send_byte(utf8_lead(3), 1'b0);
      send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
      send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
    end
    send_byte(8'h00, 1'b0);
    tx_steady = 1'b0;
  endtask

  // Mostly well-formed strings of random text; some carry a broken piece.
  task automatic test_random_strings();
    int  first_live;
    int  nchar;
    int  bad_at;
    int  k;
    bit  zero_end;
    first_live = live_items;
    // opening stretch with no idling on either side
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    while (live_items - first_live < RANDOM_ITEMS) begin
      if (live_items - first_live > 60) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      nchar    = $urandom_range(1, 6);
      bad_at   = ($urandom_range(99) < 20) ? $urandom_range(0, nchar - 1) : -1;
      zero_end = ($urandom_range(3) == 0);
      for (k = 0; k < nchar; k++) begin
        if (k == bad_at) begin
          send_broken_piece();
        end else begin
          send_good_char(!zero_end && (k == nchar - 1));
        end
      end
      if (zero_end) begin
        send_byte(8'h00, 1'($urandom_range(1)));
      end else if (bad_at == nchar - 1) begin
        send_byte(8'($urandom_range(255)), 1'b1);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ascii_passthrough();
    test_escape_lengths();
    test_decode_errors();
    test_back_pressure();
    test_random_strings();

    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/u8d_pkg.sv
rtl/core/u8d_front.sv
rtl/core/u8d_queue.sv
rtl/core/u8d_back.sv
rtl/core/utf8_to_unicode_escape_decoder_unit.sv
rtl/core/u8d_checker.sv
dv/utf8_to_unicode_escape_decoder_unit_tb.sv
